### rtl/core/crc_pkg.sv
// Package for the congestion rate controller: shared constants, register
// indexes and the command/status types between controller and datapath.
// No dependencies.
`default_nettype none

package crc_pkg;

    localparam int RATE_W  = 19;
    localparam int FRAC_W  = 17;
    localparam int CNT_W   = 16;
    localparam int STAGE_W = 9;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int DEF_ALPHA_INTERVAL    = 55;
    localparam int DEF_DECREASE_INTERVAL = 4;
    localparam int DEF_INCREASE_INTERVAL = 300;

    localparam logic [FRAC_W-1:0]  ONE_Q16   = 17'd65536;
    localparam logic [FRAC_W:0]    TWO_Q17   = 18'd131072;
    localparam logic [STAGE_W-1:0] STAGE_MAX = 9'd256;

    localparam logic [FRAC_W-1:0] RST_ALPHA_GAIN = 17'd256;
    localparam logic [FRAC_W-1:0] RST_FIRST_FRAC = 17'd65536;
    localparam logic [RATE_W-1:0] RST_MIN_RATE   = 19'd100;
    localparam logic [RATE_W-1:0] RST_RATE_INC   = 19'd5;
    localparam logic [RATE_W-1:0] RST_LINE_RATE  = 19'd100000;
    localparam logic [THR_W-1:0]  RST_STAGE_THR  = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_INC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RATE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_THR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_TARGET = 3'd6;

    localparam int ARM_ALPHA = 0;
    localparam int ARM_DEC   = 1;
    localparam int ARM_INC   = 2;

    typedef struct packed {
        logic capture;
        logic step_alpha;
        logic step_dec;
        logic step_inc;
        logic apply_notice;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic dec_rearm;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/crc_dp.sv
// Datapath: configuration registers, rate/alpha state, interval timers,
// the three multiplies and the output registers. Depends on crc_pkg.
`default_nettype none

module crc_dp #(
    parameter int ALPHA_INTERVAL_TICKS    = crc_pkg::DEF_ALPHA_INTERVAL,
    parameter int DECREASE_INTERVAL_TICKS = crc_pkg::DEF_DECREASE_INTERVAL,
    parameter int INCREASE_INTERVAL_TICKS = crc_pkg::DEF_INCREASE_INTERVAL
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [crc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_notice_arrived,
    input  wire crc_pkg::t_dp_cmd               i_cmd,
    output crc_pkg::t_dp_sts                    o_sts,
    output logic [crc_pkg::RATE_W-1:0]          o_current_rate,
    output logic [crc_pkg::RATE_W-1:0]          o_target_rate_out
);
    import crc_pkg::*;

    localparam logic [CNT_W-1:0] ALPHA_RELOAD = CNT_W'(ALPHA_INTERVAL_TICKS);
    localparam logic [CNT_W-1:0] DEC_RELOAD   = CNT_W'(DECREASE_INTERVAL_TICKS);
    localparam logic [CNT_W-1:0] INC_RELOAD   = CNT_W'(INCREASE_INTERVAL_TICKS);

    logic [FRAC_W-1:0]  r_alpha_gain;
    logic [FRAC_W-1:0]  r_first_frac;
    logic [RATE_W-1:0]  r_min_rate;
    logic [RATE_W-1:0]  r_rate_inc;
    logic [RATE_W-1:0]  r_line_rate;
    logic [THR_W-1:0]   r_stage_thr;
    logic               r_clamp_target;

    logic [RATE_W-1:0]  r_rate;
    logic [RATE_W-1:0]  r_target;
    logic [FRAC_W-1:0]  r_alpha;
    logic               r_alpha_flag;
    logic               r_dec_flag;
    logic               r_awaiting;
    logic [STAGE_W-1:0] r_stage;
    logic [CNT_W-1:0]   r_alpha_cnt;
    logic [CNT_W-1:0]   r_dec_cnt;
    logic [CNT_W-1:0]   r_inc_cnt;
    logic [2:0]         r_armed;
    logic               r_notice;

    logic [FRAC_W-1:0]  w_gain;
    logic [FRAC_W-1:0]  w_frac;
    logic [CNT_W-1:0]   w_alpha_cnt_dec;
    logic [CNT_W-1:0]   w_dec_cnt_dec;
    logic [CNT_W-1:0]   w_inc_cnt_dec;
    logic               w_alpha_fire;
    logic               w_dec_fire;
    logic               w_inc_fire;
    logic [33:0]        w_alpha_prod;
    logic [33:0]        w_alpha_acc;
    logic [FRAC_W:0]    w_dec_factor;
    logic [36:0]        w_dec_prod;
    logic [RATE_W-1:0]  w_dec_cut;
    logic [RATE_W-1:0]  w_dec_rate;
    logic [RATE_W:0]    w_inc_sum;
    logic [RATE_W-1:0]  w_inc_cap;
    logic [RATE_W-1:0]  w_inc_target;
    logic [RATE_W-1:0]  w_inc_rate;
    logic [35:0]        w_first_prod;

    always_comb begin
        w_gain = (r_alpha_gain > ONE_Q16) ? ONE_Q16 : r_alpha_gain;
        w_frac = (r_first_frac > ONE_Q16) ? ONE_Q16 : r_first_frac;

        w_alpha_cnt_dec = r_alpha_cnt - CNT_W'(1);
        w_dec_cnt_dec   = r_dec_cnt - CNT_W'(1);
        w_inc_cnt_dec   = r_inc_cnt - CNT_W'(1);
        w_alpha_fire = r_armed[ARM_ALPHA] && (w_alpha_cnt_dec == '0);
        w_dec_fire   = r_armed[ARM_DEC] && (w_dec_cnt_dec == '0);
        w_inc_fire   = r_armed[ARM_INC] && (w_inc_cnt_dec == '0);

        // alpha = ((1 - g) * alpha + flag * g) in Q1.16
        w_alpha_prod = 34'(ONE_Q16 - w_gain) * 34'(r_alpha);
        w_alpha_acc  = w_alpha_prod + (r_alpha_flag ? {1'b0, w_gain, 16'd0} : 34'd0);

        // rate * (1 - alpha / 2)
        w_dec_factor = TWO_Q17 - {1'b0, r_alpha};
        w_dec_prod   = 37'(r_rate) * 37'(w_dec_factor);
        w_dec_cut    = w_dec_prod[35:17];
        w_dec_rate   = (w_dec_cut < r_min_rate) ? r_min_rate : w_dec_cut;

        w_inc_sum    = {1'b0, r_target} + {1'b0, r_rate_inc};
        w_inc_cap    = (w_inc_sum > {1'b0, r_line_rate}) ? r_line_rate
                                                          : w_inc_sum[RATE_W-1:0];
        w_inc_target = (r_stage >= {1'b0, r_stage_thr}) ? w_inc_cap : r_target;
        w_inc_rate   = {1'b0, r_rate[RATE_W-1:1]} + {1'b0, w_inc_target[RATE_W-1:1]};

        w_first_prod = 36'(r_rate) * 36'(w_frac);

        o_sts.dec_rearm = w_dec_fire && r_dec_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_gain      <= RST_ALPHA_GAIN;
            r_first_frac      <= RST_FIRST_FRAC;
            r_min_rate        <= RST_MIN_RATE;
            r_rate_inc        <= RST_RATE_INC;
            r_line_rate       <= RST_LINE_RATE;
            r_stage_thr       <= RST_STAGE_THR;
            r_clamp_target    <= 1'b1;
            r_rate            <= RST_LINE_RATE;
            r_target          <= '0;
            r_alpha           <= ONE_Q16;
            r_alpha_flag      <= 1'b0;
            r_dec_flag        <= 1'b0;
            r_awaiting        <= 1'b1;
            r_stage           <= '0;
            r_alpha_cnt       <= '0;
            r_dec_cnt         <= '0;
            r_inc_cnt         <= '0;
            r_armed           <= '0;
            r_notice          <= 1'b0;
            o_current_rate    <= '0;
            o_target_rate_out <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ALPHA_GAIN:   r_alpha_gain   <= i_cfg_data[FRAC_W-1:0];
                    CFG_FIRST_FRAC:   r_first_frac   <= i_cfg_data[FRAC_W-1:0];
                    CFG_MIN_RATE:     r_min_rate     <= i_cfg_data[RATE_W-1:0];
                    CFG_RATE_INC:     r_rate_inc     <= i_cfg_data[RATE_W-1:0];
                    CFG_LINE_RATE: begin
                        r_line_rate <= i_cfg_data[RATE_W-1:0];
                        if (r_awaiting) begin
                            r_rate <= i_cfg_data[RATE_W-1:0];
                        end
                    end
                    CFG_STAGE_THR:    r_stage_thr    <= i_cfg_data[THR_W-1:0];
                    CFG_CLAMP_TARGET: r_clamp_target <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.capture) begin
                r_notice <= i_notice_arrived;
            end

            if (i_cmd.step_alpha && r_armed[ARM_ALPHA]) begin
                r_alpha_cnt <= w_alpha_fire ? ALPHA_RELOAD : w_alpha_cnt_dec;
                if (w_alpha_fire) begin
                    r_alpha      <= w_alpha_acc[32:16];
                    r_alpha_flag <= 1'b0;
                end
            end

            if (i_cmd.step_dec && r_armed[ARM_DEC]) begin
                r_dec_cnt <= w_dec_fire ? DEC_RELOAD : w_dec_cnt_dec;
                if (w_dec_fire && r_dec_flag) begin
                    if (r_clamp_target || (r_stage != '0)) begin
                        r_target <= r_rate;
                    end
                    r_rate           <= w_dec_rate;
                    r_stage          <= '0;
                    r_dec_flag       <= 1'b0;
                    r_inc_cnt        <= INC_RELOAD;
                    r_armed[ARM_INC] <= 1'b1;
                end
            end

            if (i_cmd.step_inc && r_armed[ARM_INC]) begin
                r_inc_cnt <= w_inc_fire ? INC_RELOAD : w_inc_cnt_dec;
                if (w_inc_fire) begin
                    r_target <= w_inc_target;
                    r_rate   <= w_inc_rate;
                    if (r_stage != STAGE_MAX) begin
                        r_stage <= r_stage + STAGE_W'(1);
                    end
                end
            end

            if (i_cmd.apply_notice && r_notice) begin
                r_alpha_flag <= 1'b1;
                r_dec_flag   <= 1'b1;
                if (r_awaiting) begin
                    r_rate             <= w_first_prod[34:16];
                    r_target           <= w_first_prod[34:16];
                    r_alpha            <= ONE_Q16;
                    r_alpha_flag       <= 1'b0;
                    r_alpha_cnt        <= ALPHA_RELOAD;
                    r_dec_cnt          <= DEC_RELOAD;
                    r_armed[ARM_ALPHA] <= 1'b1;
                    r_armed[ARM_DEC]   <= 1'b1;
                    r_awaiting         <= 1'b0;
                end
            end

            if (i_cmd.load_out) begin
                o_current_rate    <= r_rate;
                o_target_rate_out <= r_target;
            end
        end
    end

    a_alpha_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alpha <= ONE_Q16)
        else $error("alpha above one");

    a_armed_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_awaiting |-> (r_armed[ARM_ALPHA] && r_armed[ARM_DEC]))
        else $error("timers not armed after first notice");

    a_dec_rearms_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step_dec && o_sts.dec_rearm) |=>
            (r_armed[ARM_INC] && (r_inc_cnt == INC_RELOAD) && (r_stage == '0)))
        else $error("decrease did not rearm increase timer");

endmodule

`default_nettype wire

### rtl/core/crc_ctrl.sv
// Controller: sequences one tick through the alpha, decrease, increase and
// notice steps, then loads the output register. Depends on crc_pkg.
`default_nettype none

module crc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire crc_pkg::t_dp_sts i_sts,
    output crc_pkg::t_dp_cmd      o_cmd
);
    import crc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALPHA,
        S_DEC,
        S_INC,
        S_NOTE,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_rearmed;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_in_take;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_take   = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd              = '0;
        o_cmd.capture      = w_in_take;
        o_cmd.step_alpha   = (r_state == S_ALPHA);
        o_cmd.step_dec     = (r_state == S_DEC);
        o_cmd.step_inc     = (r_state == S_INC) && !r_rearmed;
        o_cmd.apply_notice = (r_state == S_NOTE);
        o_cmd.load_out     = (r_state == S_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rearmed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ALPHA;
                    end
                end
                S_ALPHA: r_state <= S_DEC;
                S_DEC: begin
                    r_rearmed <= i_sts.dec_rearm;
                    r_state   <= S_INC;
                end
                S_INC:  r_state <= S_NOTE;
                S_NOTE: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_starts_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == S_ALPHA))
        else $error("accepted request did not start a tick");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output step");

    a_no_inc_after_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && i_sts.dec_rearm) |=> !o_cmd.step_inc)
        else $error("increase timer stepped in the tick it was rearmed");

endmodule

`default_nettype wire

### rtl/core/congestion_rate_controller.sv
// Top level of the congestion rate controller: controller and datapath.
// Depends on crc_pkg, crc_ctrl and crc_dp.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------
//  in       | to block  | i_in_valid / o_in_stall    | i_notice_arrived
//  out      | from blk  | o_out_valid / i_out_stall  | o_current_rate, o_target_rate_out
//  cfg      | to block  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// From acceptance, a request steps through the alpha update, decrease check,
// increase and notice steps, then the load of the result.
// The sequencer handles one request at a time; the next is accepted once the
// result sits in the output register. Reset is synchronous, active low.
// A stalled result holds the block in its load step until it is taken.
`default_nettype none

module congestion_rate_controller #(
    parameter int ALPHA_INTERVAL_TICKS    = crc_pkg::DEF_ALPHA_INTERVAL,
    parameter int DECREASE_INTERVAL_TICKS = crc_pkg::DEF_DECREASE_INTERVAL,
    parameter int INCREASE_INTERVAL_TICKS = crc_pkg::DEF_INCREASE_INTERVAL
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_notice_arrived,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [crc_pkg::RATE_W-1:0]          o_current_rate,
    output logic [crc_pkg::RATE_W-1:0]          o_target_rate_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [crc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import crc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    crc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    crc_dp #(
        .ALPHA_INTERVAL_TICKS    (ALPHA_INTERVAL_TICKS),
        .DECREASE_INTERVAL_TICKS (DECREASE_INTERVAL_TICKS),
        .INCREASE_INTERVAL_TICKS (INCREASE_INTERVAL_TICKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_notice_arrived  (i_notice_arrived),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_current_rate    (o_current_rate),
        .o_target_rate_out (o_target_rate_out)
    );

endmodule

`default_nettype wire
